[design/bfc_pkg.sv]
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared constants and types for the binary frame bounding-box centering block.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int SIDE   = 28;
  localparam int IDX_W  = $clog2(SIDE);
  localparam int CNT_W  = $clog2(SIDE + 1);
  localparam int OFF_W  = IDX_W + 2;
  localparam int SUM_W  = OFF_W + 1;

  typedef enum logic [1:0] {
    S_LOAD,
    S_CALC,
    S_EMIT
  } bfc_state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
  } bfc_cmd_t;

  typedef struct packed {
    logic last_in;
    logic emit_last;
  } bfc_sts_t;

endpackage

[design/bfc_ctrl.sv]
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer: load rows, compute offsets, then emit the centered frame.
// ----------------------------------------------------------------------------
module bfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bfc_pkg::bfc_sts_t sts,
  output bfc_pkg::bfc_cmd_t cmd
);
  import bfc_pkg::*;

  bfc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (sts.last_in) begin
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

[design/bfc_dp.sv]
// ----------------------------------------------------------------------------
// bfc_dp
// Frame store, bounding-box tracking, offset computation and the row merger
// that builds each centered output row.
// ----------------------------------------------------------------------------
module bfc_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [bfc_pkg::SIDE-1:0] in_row_pixels,
  input  bfc_pkg::bfc_cmd_t        cmd,
  output bfc_pkg::bfc_sts_t        sts,
  output logic                     out_strobe,
  output logic [bfc_pkg::SIDE-1:0] out_centred_row,
  output logic                     out_last_row
);
  import bfc_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIDE - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SIDE);

  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [SUM_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > SUM_W'(SIDE - 1)) begin
      res = LAST_IDX;
    end else begin
      res = v[IDX_W-1:0];
    end
    return res;
  endfunction

  logic [SIDE-1:0] mem [SIDE];
  logic [SIDE-1:0] rd_r;

  logic [IDX_W-1:0] rows_r;
  logic [IDX_W-1:0] rmin_r, rmax_r, cmin_r, cmax_r;
  logic             any_r;

  logic signed [OFF_W-1:0] row_off_r, col_off_r;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        j_r;
  logic [SIDE-1:0]         acc_r;

  logic [IDX_W-1:0] row_cmin, row_cmax;
  logic             row_any;

  // first and last set column of the incoming row
  always_comb begin
    row_cmin = LAST_IDX;
    row_cmax = '0;
    for (int c = SIDE - 1; c >= 0; c--) begin
      if (in_row_pixels[c]) row_cmin = IDX_W'(c);
    end
    for (int c = 0; c < SIDE; c++) begin
      if (in_row_pixels[c]) row_cmax = IDX_W'(c);
    end
  end
  assign row_any = |in_row_pixels;

  // offsets from the tracked box
  logic [IDX_W-1:0]        rcen, ccen;
  logic signed [OFF_W-1:0] row_off_nxt, col_off_nxt;
  always_comb begin
    rcen        = rmin_r + ((rmax_r - rmin_r) >> 1);
    ccen        = cmin_r + ((cmax_r - cmin_r) >> 1);
    row_off_nxt = OFF_W'(SIDE / 2) - $signed({2'b00, rcen});
    col_off_nxt = OFF_W'(SIDE / 2) - $signed({2'b00, ccen});
  end

  // target row of the current source row and its column-shifted pixels
  logic [IDX_W-1:0] tgt;
  logic [SIDE-1:0]  shifted;
  logic             take;
  always_comb begin
    tgt = clamp_idx($signed({2'b00, k_r[IDX_W-1:0]}) + SUM_W'(row_off_r));
  end

  always_comb begin
    logic [IDX_W-1:0] p;
    shifted = '0;
    for (int c = 0; c < SIDE; c++) begin
      p = clamp_idx(SUM_W'(c) + SUM_W'(col_off_r));
      if (rd_r[c]) shifted[p] = 1'b1;
    end
  end

  assign take          = (k_r < CNT_END) && (tgt == j_r);
  assign sts.last_in   = (rows_r == LAST_IDX);
  // only looked at while emitting
  assign sts.emit_last = !take && (j_r == LAST_IDX);

  always_comb begin
    k_nxt = k_r;
    if (cmd.calc) begin
      k_nxt = '0;
    end else if (cmd.emit && take) begin
      k_nxt = k_r + CNT_W'(1);
    end
  end

  // frame store: one write port while loading, registered read for the merger
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[rows_r] <= in_row_pixels;
    end
    rd_r <= mem[k_nxt[IDX_W-1:0]];
  end

  // box tracking and row count
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.calc) begin
      rows_r <= '0;
      rmin_r <= LAST_IDX;
      rmax_r <= '0;
      cmin_r <= LAST_IDX;
      cmax_r <= '0;
      any_r  <= 1'b0;
    end else if (cmd.load) begin
      rows_r <= sts.last_in ? rows_r : rows_r + IDX_W'(1);
      if (row_any) begin
        if (rows_r < rmin_r)   rmin_r <= rows_r;
        if (rows_r > rmax_r)   rmax_r <= rows_r;
        if (row_cmin < cmin_r) cmin_r <= row_cmin;
        if (row_cmax > cmax_r) cmax_r <= row_cmax;
        any_r <= 1'b1;
      end
    end
  end

  // merger: or source rows into the current output row, flush on row change
  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.calc) begin
      // an empty frame has only zero rows, so any offset gives zeros
      row_off_r <= any_r ? row_off_nxt : '0;
      col_off_r <= any_r ? col_off_nxt : '0;
      j_r       <= '0;
      acc_r     <= '0;
    end else if (cmd.emit) begin
      if (take) begin
        acc_r <= acc_r | shifted;
      end else begin
        acc_r <= '0;
        j_r   <= j_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit && !take;
    end
    if (cmd.emit && !take) begin
      out_centred_row <= acc_r;
      out_last_row    <= (j_r == LAST_IDX);
    end
  end

endmodule

[design/binary_frame_bbox_centering_top.sv]
// ----------------------------------------------------------------------------
// binary_frame_bbox_centering_top
// Loads a square binary frame row by row, then emits it with the bounding
// box of set pixels moved to the frame center, edges clamped.
// ----------------------------------------------------------------------------
// channel   ports                               transfer
// input     start, busy, in_row_pixels          start high and busy low
// result    out_strobe, out_centred_row,        out_strobe high, one cycle
//           out_last_row
//
// one row is taken per cycle while loading; after the last row the block is
// busy for the offset step and then the merge, in which each source row is
// merged and each output row is flushed in turn, with one frame store read
// per cycle, and emits SIDE rows, the last marked by out_last_row.
// rst_n is synchronous and clears the sequencer and the box tracking.
// the receiver cannot stall; results are strobed for a single cycle.
module binary_frame_bbox_centering_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [bfc_pkg::SIDE-1:0] in_row_pixels,
  output logic                     out_strobe,
  output logic [bfc_pkg::SIDE-1:0] out_centred_row,
  output logic                     out_last_row
);
  import bfc_pkg::*;

  bfc_cmd_t cmd;
  bfc_sts_t sts;

  bfc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bfc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_row_pixels   (in_row_pixels),
    .cmd             (cmd),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_centred_row (out_centred_row),
    .out_last_row    (out_last_row)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame-level test of binary_frame_bbox_centering_top: rows go in through the
// start/busy transfer in bursts with random gaps, and every strobed output
// row is compared with rows centered by a bounding-box predictor kept in the
// bench.
// ----------------------------------------------------------------------------
module tb;

  localparam int SIDE        = bfc_pkg::SIDE;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 80;

  typedef logic [SIDE-1:0] row_t;

  typedef struct {
    row_t row;
    logic last;
  } centred_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  row_t in_row_pixels = '0;
  logic out_strobe;
  row_t out_centred_row;
  logic out_last_row;

  // predictor state for the frame being loaded
  row_t frame_rows[SIDE];
  int   rows_in;
  int   box_rmin, box_rmax, box_cmin, box_cmax;
  bit   pixel_seen;

  centred_item_t expected_rows[$];
  int   errors = 0;
  int   cycle_count = 0;
  int   burst_left = 0;

  binary_frame_bbox_centering_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_row_pixels  (in_row_pixels),
    .out_strobe     (out_strobe),
    .out_centred_row(out_centred_row),
    .out_last_row   (out_last_row)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d rows still expected", $time, expected_rows.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int clamp_pos(int v);
    if (v < 0) return 0;
    if (v > SIDE - 1) return SIDE - 1;
    return v;
  endfunction

  function automatic void clear_box();
    rows_in    = 0;
    box_rmin   = SIDE - 1;
    box_rmax   = 0;
    box_cmin   = SIDE - 1;
    box_cmax   = 0;
    pixel_seen = 1'b0;
  endfunction

  // track one accepted row; on the last row queue the whole centered frame
  function automatic void absorb_row(row_t r);
    int idx;
    int row_off;
    int col_off;
    int dr;
    row_t centred[SIDE];
    centred_item_t item;
    idx = rows_in;
    if (idx >= SIDE) idx = 0;
    frame_rows[idx] = r;
    if (r != '0) begin
      if (idx < box_rmin) box_rmin = idx;
      if (idx > box_rmax) box_rmax = idx;
      for (int c = 0; c < SIDE; c++) begin
        if (r[c]) begin
          if (c < box_cmin) box_cmin = c;
          if (c > box_cmax) box_cmax = c;
        end
      end
      pixel_seen = 1'b1;
    end
    if (idx + 1 < SIDE) begin
      rows_in = idx + 1;
      return;
    end
    for (int k = 0; k < SIDE; k++) centred[k] = '0;
    if (pixel_seen) begin
      row_off = SIDE / 2 - ((box_rmax - box_rmin) / 2 + box_rmin);
      col_off = SIDE / 2 - ((box_cmax - box_cmin) / 2 + box_cmin);
      for (int k = 0; k < SIDE; k++) begin
        dr = clamp_pos(k + row_off);
        for (int c = 0; c < SIDE; c++) begin
          if (frame_rows[k][c]) centred[dr][clamp_pos(c + col_off)] = 1'b1;
        end
      end
    end
    for (int k = 0; k < SIDE; k++) begin
      item.row  = centred[k];
      item.last = (k == SIDE - 1);
      expected_rows.push_back(item);
    end
    clear_box();
  endfunction

  // one row transfer; bursts of random length with random gaps in between
  task automatic send_row(row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        in_row_pixels <= row_t'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    start <= 1'b1;
    in_row_pixels <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_row(r);
    burst_left--;
  endtask

  task automatic send_frame(row_t img[SIDE]);
    for (int k = 0; k < SIDE; k++) send_row(img[k]);
  endtask

  always @(posedge clk) begin
    centred_item_t exp_item;
    if (rst_n && out_strobe) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row, expected none actual %h last %b",
                 $time, out_centred_row, out_last_row);
        errors++;
      end else begin
        exp_item = expected_rows.pop_front();
        if (out_centred_row !== exp_item.row) begin
          $display("%0t: centred_row mismatch expected %h actual %h",
                   $time, exp_item.row, out_centred_row);
          errors++;
        end
        if (out_last_row !== exp_item.last) begin
          $display("%0t: last_row mismatch expected %b actual %b",
                   $time, exp_item.last, out_last_row);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_frame();
    row_t img[SIDE];
    for (int k = 0; k < SIDE; k++) img[k] = '0;
    send_frame(img);
  endtask

  // box covers the frame, so everything moves by one and the edge rows merge
  task automatic test_full_frame();
    row_t img[SIDE];
    for (int k = 0; k < SIDE; k++) img[k] = '1;
    send_frame(img);
  endtask

  // lone pixel in opposite corners gives the largest shifts both ways
  task automatic test_corner_pixels();
    row_t img[SIDE];
    for (int k = 0; k < SIDE; k++) img[k] = '0;
    img[0] = row_t'(1);
    send_frame(img);
    for (int k = 0; k < SIDE; k++) img[k] = '0;
    img[SIDE-1] = row_t'(1) << (SIDE - 1);
    send_frame(img);
  endtask

  task automatic test_random_frames(int n);
    row_t img[SIDE];
    int kind, rmin, rmax, cmin, cmax, pr, pc;
    logic [63:0] mask;
    for (int f = 0; f < n; f++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < SIDE; k++) img[k] = '0;
      if (kind <= 2) begin
        // blob inside a random box
        rmin = $urandom_range(0, SIDE - 1);
        rmax = $urandom_range(rmin, SIDE - 1);
        cmin = $urandom_range(0, SIDE - 1);
        cmax = $urandom_range(cmin, SIDE - 1);
        mask = ((64'd1 << (cmax - cmin + 1)) - 64'd1) << cmin;
        for (int k = rmin; k <= rmax; k++) begin
          img[k] = row_t'($urandom) & row_t'(mask);
          if (kind == 2) img[k] = img[k] & row_t'($urandom);
        end
      end else if (kind <= 4) begin
        for (int k = 0; k < SIDE; k++)
          img[k] = row_t'($urandom) & row_t'($urandom) & row_t'($urandom);
      end else if (kind <= 6) begin
        for (int k = 0; k < SIDE; k++) img[k] = row_t'($urandom);
      end else if (kind <= 8) begin
        pr = $urandom_range(0, SIDE - 1);
        pc = $urandom_range(0, SIDE - 1);
        img[pr] = row_t'(1) << pc;
      end
      send_frame(img);
    end
  endtask

  initial begin
    clear_box();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_frame();
    test_full_frame();
    test_corner_pixels();
    test_random_frames(9);
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
design/bfc_pkg.sv
design/bfc_ctrl.sv
design/bfc_dp.sv
design/binary_frame_bbox_centering_top.sv
bench/tb.sv
